// ----- hw/rtl/exl_pkg.sv -----
package exl_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int SLOTS       = 4;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [3:0] TK_LPAREN = 4'd0;
  localparam logic [3:0] TK_RPAREN = 4'd1;
  localparam logic [3:0] TK_PLUS   = 4'd2;
  localparam logic [3:0] TK_MINUS  = 4'd3;
  localparam logic [3:0] TK_STAR   = 4'd4;
  localparam logic [3:0] TK_SLASH  = 4'd5;
  localparam logic [3:0] TK_NUMBER = 4'd6;
  localparam logic [3:0] TK_STRING = 4'd7;
  localparam logic [3:0] TK_TRUE   = 4'd8;
  localparam logic [3:0] TK_FALSE  = 4'd9;
  localparam logic [3:0] TK_DEFINE = 4'd10;
  localparam logic [3:0] TK_VAR    = 4'd11;
  localparam logic [3:0] TK_IDENT  = 4'd12;
  localparam logic [3:0] TK_EOF    = 4'd13;
  localparam logic [3:0] TK_ERROR  = 4'd14;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DOT      = 2'd1;
  localparam logic [1:0] ERR_STRING   = 2'd2;
  localparam logic [1:0] ERR_UNEXPECT = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } exl_tok_t;

  typedef struct packed {
    logic [SLOTS-1:0]     valid;
    exl_tok_t [SLOTS-1:0] tok;
  } exl_wr_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c inside {CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_STAR:   k = TK_STAR;
      default:   k = TK_SLASH;
    endcase
    return k;
  endfunction

  // keywords: 0 true, 1 false, 2 define, 3 var
  function automatic logic [2:0] kw_len(logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd6;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kw_kind(logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = TK_TRUE;
      2'd1:    n = TK_FALSE;
      2'd2:    n = TK_DEFINE;
      default: n = TK_VAR;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] pos);
    logic [7:0] c;
    case ({k, pos})
      {2'd0, 3'd0}: c = "t";
      {2'd0, 3'd1}: c = "r";
      {2'd0, 3'd2}: c = "u";
      {2'd0, 3'd3}: c = "e";
      {2'd1, 3'd0}: c = "f";
      {2'd1, 3'd1}: c = "a";
      {2'd1, 3'd2}: c = "l";
      {2'd1, 3'd3}: c = "s";
      {2'd1, 3'd4}: c = "e";
      {2'd2, 3'd0}: c = "d";
      {2'd2, 3'd1}: c = "e";
      {2'd2, 3'd2}: c = "f";
      {2'd2, 3'd3}: c = "i";
      {2'd2, 3'd4}: c = "n";
      {2'd2, 3'd5}: c = "e";
      {2'd3, 3'd0}: c = "v";
      {2'd3, 3'd1}: c = "a";
      {2'd3, 3'd2}: c = "r";
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  // in_range: position fits in 3 bits
  function automatic logic [3:0] kw_update(logic [3:0] alive, logic in_range,
                                           logic [2:0] pos, logic [7:0] c);
    logic [3:0] r;
    r = alive;
    for (int k = 0; k < 4; k++) begin
      if (!(in_range && (pos < kw_len(2'(k))) && (kw_char(2'(k), pos) == c))) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/exl_front.sv -----
module exl_front #(
  parameter int COLUMN_BITS = exl_pkg::COLUMN_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       ch,
  input  logic             has_char,
  input  logic             end_of_source,
  output exl_pkg::exl_wr_t wr
);

  localparam int CB = COLUMN_BITS;
  localparam int WW = (CB + 1 > 16) ? CB + 1 : 16;

  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_INT   = 7'b0000010,
    M_DOT   = 7'b0000100,
    M_FRAC  = 7'b0001000,
    M_STR   = 7'b0010000,
    M_IDENT = 7'b0100000,
    M_HALT  = 7'b1000000
  } exl_mode_t;

  exl_mode_t     mode, mode_next;
  logic [CB-1:0] col, col_next;
  logic [CB-1:0] ps, ps_next;
  logic [3:0]    alive, alive_next;

  function automatic exl_pkg::exl_tok_t mk(logic [3:0] kind, logic [CB-1:0] start,
                                           logic [CB:0] len, logic [1:0] err);
    logic [WW-1:0]     s;
    logic [WW-1:0]     l;
    exl_pkg::exl_tok_t t;
    s = WW'(start);
    l = WW'(len);
    t.kind   = kind;
    t.start  = s[15:0];
    t.length = l[15:0];
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] ident_kind(logic [3:0] al, logic [CB-1:0] len);
    logic [3:0] k;
    k = exl_pkg::TK_IDENT;
    for (int i = 3; i >= 0; i--) begin
      if (al[i] && (len == CB'(exl_pkg::kw_len(2'(i))))) begin
        k = exl_pkg::kw_kind(2'(i));
      end
    end
    return k;
  endfunction

  function automatic logic [3:0] alive_step(logic [3:0] al, logic [CB-1:0] pos,
                                            logic [7:0] c);
    return exl_pkg::kw_update(al, pos < CB'(8), pos[2:0], c);
  endfunction

  logic [CB-1:0] len_c;
  logic [CB-1:0] len_e;
  logic          do_start;
  logic          higher;

  always_comb begin
    mode_next  = mode;
    col_next   = col;
    ps_next    = ps;
    alive_next = alive;
    wr         = '0;
    do_start   = 1'b0;
    len_c      = col - ps;
    len_e      = '0;
    higher     = 1'b0;

    if (take && mode != M_HALT) begin
      if (has_char) begin
        case (mode)
          M_INT, M_FRAC: begin
            if (exl_pkg::is_digit(ch)) begin
              mode_next = mode;
            end else if (mode == M_INT && ch == exl_pkg::CH_DOT) begin
              mode_next = M_DOT;
            end else begin
              wr.valid[0] = 1'b1;
              wr.tok[0]   = mk(exl_pkg::TK_NUMBER, ps, {1'b0, len_c}, exl_pkg::ERR_NONE);
              do_start    = 1'b1;
            end
          end
          M_DOT: begin
            if (exl_pkg::is_digit(ch)) begin
              mode_next = M_FRAC;
            end else begin
              wr.valid[0] = 1'b1;
              wr.tok[0]   = mk(exl_pkg::TK_ERROR, ps, '0, exl_pkg::ERR_DOT);
              mode_next   = M_HALT;
            end
          end
          M_STR: begin
            if (ch == exl_pkg::CH_QUOTE) begin
              wr.valid[0] = 1'b1;
              wr.tok[0]   = mk(exl_pkg::TK_STRING, ps,
                               {1'b0, col} + (CB+1)'(1) - {1'b0, ps}, exl_pkg::ERR_NONE);
              mode_next   = M_IDLE;
            end
          end
          M_IDENT: begin
            if (exl_pkg::is_ident_char(ch)) begin
              alive_next = alive_step(alive, len_c, ch);
            end else begin
              wr.valid[0] = 1'b1;
              wr.tok[0]   = mk(ident_kind(alive, len_c), ps, {1'b0, len_c},
                               exl_pkg::ERR_NONE);
              do_start    = 1'b1;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        if (do_start) begin
          mode_next = M_IDLE;
          if (exl_pkg::is_punct(ch)) begin
            wr.valid[1] = 1'b1;
            wr.tok[1]   = mk(exl_pkg::punct_kind(ch), col, (CB+1)'(1), exl_pkg::ERR_NONE);
          end else if (exl_pkg::is_ws(ch)) begin
            mode_next = M_IDLE;
          end else if (ch == exl_pkg::CH_QUOTE) begin
            mode_next = M_STR;
            ps_next   = col;
          end else if (exl_pkg::is_digit(ch)) begin
            mode_next = M_INT;
            ps_next   = col;
          end else if (exl_pkg::is_alpha(ch)) begin
            mode_next  = M_IDENT;
            ps_next    = col;
            alive_next = alive_step(4'hF, '0, ch);
          end else begin
            wr.valid[1] = 1'b1;
            wr.tok[1]   = mk(exl_pkg::TK_ERROR, col, '0, exl_pkg::ERR_UNEXPECT);
            mode_next   = M_HALT;
          end
        end

        col_next = (col == '1) ? col : col + CB'(1);
      end

      if (end_of_source) begin
        len_e = col_next - ps_next;
        case (mode_next)
          M_INT, M_FRAC: begin
            wr.valid[2] = 1'b1;
            wr.tok[2]   = mk(exl_pkg::TK_NUMBER, ps_next, {1'b0, len_e}, exl_pkg::ERR_NONE);
          end
          M_DOT: begin
            wr.valid[2] = 1'b1;
            wr.tok[2]   = mk(exl_pkg::TK_ERROR, ps_next, '0, exl_pkg::ERR_DOT);
          end
          M_STR: begin
            wr.valid[2] = 1'b1;
            wr.tok[2]   = mk(exl_pkg::TK_ERROR, ps_next, '0, exl_pkg::ERR_STRING);
          end
          M_IDENT: begin
            wr.valid[2] = 1'b1;
            wr.tok[2]   = mk(ident_kind(alive_next, len_e), ps_next, {1'b0, len_e},
                             exl_pkg::ERR_NONE);
          end
          default: begin
            wr.valid[2] = 1'b0;
          end
        endcase
        if (mode_next != M_HALT && mode_next != M_DOT && mode_next != M_STR) begin
          wr.valid[3] = 1'b1;
          wr.tok[3]   = mk(exl_pkg::TK_EOF, col_next, '0, exl_pkg::ERR_NONE);
        end
        mode_next  = M_IDLE;
        col_next   = '0;
        ps_next    = '0;
        alive_next = '0;
      end
    end else if (take && end_of_source) begin
      mode_next  = M_IDLE;
      col_next   = '0;
      ps_next    = '0;
      alive_next = '0;
    end

    for (int i = exl_pkg::SLOTS - 1; i >= 0; i--) begin
      wr.tok[i].last = wr.valid[i] & ~higher;
      higher         = higher | wr.valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      col   <= '0;
      ps    <= '0;
      alive <= '0;
    end else begin
      mode  <= mode_next;
      col   <= col_next;
      ps    <= ps_next;
      alive <= alive_next;
    end
  end

endmodule

// ----- hw/rtl/exl_queue.sv -----
module exl_queue #(
  parameter int DEPTH = exl_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  exl_pkg::exl_wr_t  wr,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output exl_pkg::exl_tok_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int S  = exl_pkg::SLOTS;

  exl_pkg::exl_tok_t mem [DEPTH];
  logic [PW-1:0]     rd_ptr, wr_ptr;
  logic [CW-1:0]     count;
  logic [PW-1:0]     off [S];
  logic [CW-1:0]     n_wr;
  logic              do_pop;

  always_comb begin
    n_wr = '0;
    for (int i = 0; i < S; i++) begin
      off[i] = n_wr[PW-1:0];
      n_wr   = n_wr + CW'(wr.valid[i]);
    end
  end

  assign empty  = (count == '0);
  assign full   = (count > CW'(DEPTH - S));
  assign do_pop = pop && !empty;
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < S; i++) begin
      if (wr.valid[i]) begin
        mem[wr_ptr + off[i]] <= wr.tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_wr);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + n_wr - CW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/expression_lexer.sv -----
// A pushed character's tokens are registered into the result queue in the cycle after push.
// Throughput: one character per cycle while the result queue has room for four
// entries; results leave one per cycle, so items making several tokens drain slower.
// Reset (synchronous, rst high) returns the scanner to idle at column zero and
// empties the result queue; no clearing pass is needed.
module expression_lexer #(
  parameter int COLUMN_BITS = exl_pkg::COLUMN_BITS,
  parameter int QUEUE_DEPTH = exl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        has_char,
  input  logic        end_of_source,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  exl_pkg::exl_wr_t  wr;
  exl_pkg::exl_tok_t head;
  logic              take;

  assign take = push && !full;

  exl_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .ch           (ch),
    .has_char     (has_char),
    .end_of_source(end_of_source),
    .wr           (wr)
  );

  exl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .empty(empty),
    .head (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign error_code   = head.err;
  assign last_of_run  = head.last;

endmodule
